[hdl/qwr_pkg.sv]
// Shared constants, codes and types for the ordered key queue.
package qwr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 16;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_RM_KEY = 2'd1,
    OP_RM_POS = 2'd2,
    OP_SERVE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SERVE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic                we;
    logic [PTR_BITS-1:0] waddr;
    logic [KEY_BITS-1:0] wdata;
    logic [PTR_BITS-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [CNT_BITS-1:0] count;
    status_t             status;
  } res_t;

endpackage

[hdl/fifo_queue_with_removal.sv]
// Top level of the ordered key queue: sequencer, entry RAM and output register.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_op, in_player_key, in_position
//  out_     output     out_valid/out_ready  out_served_key, out_entry_count, out_status
//
// One request at a time. Append and up-front rejects go to S_RESULT, serve via S_SERVE.
// Remove by key scans one entry per cycle (one RAM read port), then compacts
// one entry per cycle after the match.
// Remove by position at the head just advances the head; otherwise it compacts in S_SHIFT.
// Reset clears state, head, count and the pending flag; the entry RAM is not cleared.
// A result held by out_ready low stalls the next result, and with it further input accept.
module fifo_queue_with_removal
  import qwr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_player_key,
  input  logic [3:0]  in_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_served_key,
  output logic [4:0]  out_entry_count,
  output logic [1:0]  out_status
);

  mem_req_t            mem_req;
  logic [KEY_BITS-1:0] mem_rdata;
  logic                res_valid;
  logic                res_ready;
  res_t                res;

  logic                out_valid_r, out_valid_nxt;
  res_t                out_r;

  qwr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_player_key (in_player_key),
    .in_position   (in_position),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  qwr_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (KEY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_served_key  = 16'(out_r.key);
  assign out_entry_count = 5'(out_r.count);
  assign out_status      = out_r.status;

endmodule

[hdl/qwr_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
module qwr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/qwr_ctrl.sv]
// Sequencer: append, key search, gap compaction and serve over the entry RAM.
module qwr_ctrl
  import qwr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [15:0]         in_player_key,
  input  logic [3:0]          in_position,
  output mem_req_t            mem_req,
  input  logic [KEY_BITS-1:0] mem_rdata,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res
);

  state_t              state_r, state_nxt;
  logic [PTR_BITS-1:0] head_r, head_nxt;
  logic [CNT_BITS-1:0] occ_r, occ_nxt;
  logic [CNT_BITS-1:0] off_r, off_nxt;
  logic                pend_r, pend_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [KEY_BITS-1:0] res_key_r, res_key_nxt;
  status_t             res_stat_r, res_stat_nxt;
  logic [CNT_BITS-1:0] pos_ext;

  function automatic logic [PTR_BITS-1:0] slot(input logic [PTR_BITS-1:0] h,
                                                input logic [CNT_BITS-1:0] o);
    logic [CNT_BITS:0] s;
    s = (CNT_BITS+1)'(h) + (CNT_BITS+1)'(o);
    if (s >= (CNT_BITS+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_BITS+1)'(QUEUE_DEPTH);
    end
    return s[PTR_BITS-1:0];
  endfunction

  assign pos_ext = CNT_BITS'(in_position);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    key_r      <= key_nxt;
    res_key_r  <= res_key_nxt;
    res_stat_r <= res_stat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    off_nxt       = off_r;
    pend_nxt      = pend_r;
    key_nxt       = key_r;
    res_key_nxt   = res_key_r;
    res_stat_nxt  = res_stat_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = slot(head_r, off_r - CNT_BITS'(2));
    mem_req.wdata = mem_rdata;
    mem_req.raddr = slot(head_r, off_r);

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt      = in_player_key[KEY_BITS-1:0];
          res_key_nxt  = '0;
          res_stat_nxt = ST_OK;
          off_nxt      = '0;
          pend_nxt     = 1'b0;
          unique case (op_t'(in_op))
            OP_APPEND: begin
              state_nxt = S_RESULT;
              if (occ_r == CNT_BITS'(QUEUE_DEPTH)) begin
                res_stat_nxt = ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = slot(head_r, occ_r);
                mem_req.wdata = in_player_key[KEY_BITS-1:0];
                occ_nxt       = occ_r + CNT_BITS'(1);
              end
            end
            OP_RM_KEY: begin
              if (occ_r == '0) begin
                res_stat_nxt = ST_MISS;
                state_nxt    = S_RESULT;
              end else begin
                mem_req.raddr = head_r;
                state_nxt     = S_SCAN;
              end
            end
            OP_RM_POS: begin
              if (pos_ext >= occ_r) begin
                res_stat_nxt = ST_RANGE;
                state_nxt    = S_RESULT;
              end else if (pos_ext == '0) begin
                head_nxt  = slot(head_r, CNT_BITS'(1));
                occ_nxt   = occ_r - CNT_BITS'(1);
                state_nxt = S_RESULT;
              end else begin
                off_nxt   = pos_ext + CNT_BITS'(1);
                state_nxt = S_SHIFT;
              end
            end
            OP_SERVE: begin
              if (occ_r == '0) begin
                res_stat_nxt = ST_MISS;
                state_nxt    = S_RESULT;
              end else begin
                mem_req.raddr = head_r;
                state_nxt     = S_SERVE;
              end
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end

      S_SERVE: begin
        res_key_nxt = mem_rdata;
        head_nxt    = slot(head_r, CNT_BITS'(1));
        occ_nxt     = occ_r - CNT_BITS'(1);
        state_nxt   = S_RESULT;
      end

      // rdata holds the entry at offset off_r
      S_SCAN: begin
        mem_req.raddr = slot(head_r, off_r + CNT_BITS'(1));
        if (mem_rdata == key_r) begin
          if (off_r == '0) begin
            head_nxt  = slot(head_r, CNT_BITS'(1));
            occ_nxt   = occ_r - CNT_BITS'(1);
            state_nxt = S_RESULT;
          end else begin
            off_nxt   = off_r + CNT_BITS'(1);
            pend_nxt  = 1'b0;
            state_nxt = S_SHIFT;
          end
        end else if (off_r + CNT_BITS'(1) == occ_r) begin
          res_stat_nxt = ST_MISS;
          state_nxt    = S_RESULT;
        end else begin
          off_nxt = off_r + CNT_BITS'(1);
        end
      end

      // read offset off_r, write the beat read last cycle one slot lower
      S_SHIFT: begin
        mem_req.we = pend_r;
        if (off_r == occ_r) begin
          pend_nxt  = 1'b0;
          occ_nxt   = occ_r - CNT_BITS'(1);
          state_nxt = S_RESULT;
        end else begin
          off_nxt  = off_r + CNT_BITS'(1);
          pend_nxt = 1'b1;
        end
      end

      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.key    = res_key_r;
  assign res.count  = occ_r;
  assign res.status = res_stat_r;

endmodule
